@@ sv/arst_pkg.sv @@
// ----------------------------------------------------------------------------
// arst_pkg
// Shared types and constants of the alternating range sum tree unit.
// ----------------------------------------------------------------------------
package arst_pkg;

  localparam int SIZE_DEF = 1024;
  localparam int SUM_W    = 48;
  localparam int VAL_W    = 32;
  localparam int CNT_W    = 11;
  localparam int POS_W    = 10;

  localparam logic [CNT_W-1:0] CNT_RST = 11'd1024;

  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  typedef struct packed {
    logic                    req_type;
    logic [POS_W-1:0]        start_index;
    logic [CNT_W-1:0]        end_index;
    logic signed [VAL_W-1:0] new_value;
  } req_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] range_sum;
  } rsp_t;

  typedef struct packed {
    logic [CNT_W-1:0] element_count;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_U_RD,
    ST_U_ADD,
    ST_Q_L,
    ST_Q_LACC,
    ST_Q_R,
    ST_Q_RACC,
    ST_DONE
  } state_e;

endpackage

@@ sv/arst_stream_if.sv @@
// ----------------------------------------------------------------------------
// arst_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface arst_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ sv/arst_mem.sv @@
// ----------------------------------------------------------------------------
// arst_mem
// Single-port-write, single-port-read tree node memory with registered read.
// ----------------------------------------------------------------------------
module arst_mem #(
  parameter int DEPTH = 2 * arst_pkg::SIZE_DEF
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  logic [arst_pkg::SUM_W-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [$clog2(DEPTH)-1:0]   raddr_i,
  output logic [arst_pkg::SUM_W-1:0] rdata_o
);
  import arst_pkg::*;

  logic [SUM_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

@@ sv/arst_alu.sv @@
// ----------------------------------------------------------------------------
// arst_alu
// Shared three-operand adder: y = a + b - c, wrapping at the sum width.
// ----------------------------------------------------------------------------
module arst_alu (
  input  logic [arst_pkg::SUM_W-1:0] a_i,
  input  logic [arst_pkg::SUM_W-1:0] b_i,
  input  logic [arst_pkg::SUM_W-1:0] c_i,
  output logic [arst_pkg::SUM_W-1:0] y_o
);
  import arst_pkg::*;

  assign y_o = a_i + b_i - c_i;

endmodule

@@ sv/alternating_range_sum_tree_unit.sv @@
// ----------------------------------------------------------------------------
// alternating_range_sum_tree_unit
// Two sum trees (0-based even and odd positions) with point update and
// alternating range sum query.
//
// Channels: req carries one request per transaction (update or query), rsp
// returns one range_sum per query. Updates give no response. cfg writes
// element_count; the user is to do so only while the block is idle, which
// the block itself does not enforce. An update writes the leaf, then per
// tree level does a sibling read and then an add with the parent write. A
// query visits at most two nodes per level, each needing a read and an
// accumulate; an empty range skips the tree walk and answers with zero.
// The node memory read port and the one shared adder set this order of
// steps. req is not ready while an item is at work. After reset a clearing
// pass zeroes all 2*SIZE nodes of both trees, one node per cycle, before
// the first request is taken. The response sits in an output register: a
// stalled receiver does not block the next update, and a query only waits
// at its end until the previous response has been taken.
// ----------------------------------------------------------------------------
module alternating_range_sum_tree_unit #(
  parameter int SIZE = arst_pkg::SIZE_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  arst_stream_if.sink   req,
  arst_stream_if.source rsp,
  arst_stream_if.sink   cfg
);
  import arst_pkg::*;

  localparam int AW = $clog2(2 * SIZE);
  localparam int NW = AW + 1;
  localparam int CW = ($clog2(SIZE + 1) > CNT_W) ? $clog2(SIZE + 1) : CNT_W;
  localparam logic [AW-1:0] CLR_LAST = AW'(2 * SIZE - 1);

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q;
  logic [NW-1:0]     lnode_q, lnode_d;
  logic [NW-1:0]     rnode_q, rnode_d;
  logic [SUM_W-1:0]  acc_q, acc_d;
  logic              par_q, par_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic              out_valid_q, out_valid_d;
  logic [SUM_W-1:0]  out_data_q, out_data_d;

  logic              we_odd, we_even, mem_re;
  logic [AW-1:0]     waddr, raddr;
  logic [SUM_W-1:0]  wdata, odd_rd, even_rd;
  logic [SUM_W-1:0]  alu_a, alu_b, alu_c, alu_y;

  req_t              rq;
  logic              req_fire;
  logic [CW-1:0]     count_c, end_c, start_c;
  logic              upd_ok, qry_empty, l_lt_r, can_load;
  logic [SUM_W-1:0]  val_ext;
  logic [NW-1:0]     leaf, r_dec;

  assign rq        = req.data;
  assign req.ready = (state_q == ST_IDLE);
  assign req_fire  = req.valid & req.ready;
  assign cfg.ready = 1'b1;
  assign rsp.valid = out_valid_q;
  assign rsp.data  = rsp_t'(out_data_q);

  assign count_c   = (CW'(count_q) < CW'(SIZE)) ? CW'(count_q) : CW'(SIZE);
  assign start_c   = CW'(rq.start_index);
  assign end_c     = (CW'(rq.end_index) > count_c) ? count_c : CW'(rq.end_index);
  assign upd_ok    = (start_c < count_c);
  assign qry_empty = (start_c >= end_c);
  assign val_ext   = {{(SUM_W - VAL_W){rq.new_value[VAL_W-1]}}, rq.new_value};
  assign leaf      = NW'(rq.start_index) + NW'(SIZE);
  assign l_lt_r    = (lnode_q < rnode_q);
  assign r_dec     = rnode_q - NW'(1);
  assign can_load  = ~out_valid_q | rsp.ready;

  arst_mem #(.DEPTH(2 * SIZE)) u_odd_mem (
    .clk_i   (clk_i),
    .we_i    (we_odd),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (mem_re),
    .raddr_i (raddr),
    .rdata_o (odd_rd)
  );

  arst_mem #(.DEPTH(2 * SIZE)) u_even_mem (
    .clk_i   (clk_i),
    .we_i    (we_even),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (mem_re),
    .raddr_i (raddr),
    .rdata_o (even_rd)
  );

  arst_alu u_alu (
    .a_i (alu_a),
    .b_i (alu_b),
    .c_i (alu_c),
    .y_o (alu_y)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == CLR_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_fire) begin
          if (rq.req_type == REQ_QUERY) begin
            state_d = qry_empty ? ST_DONE : ST_Q_L;
          end else if (upd_ok) begin
            state_d = ST_U_RD;
          end
        end
      end
      ST_U_RD: begin
        state_d = (lnode_q == NW'(1)) ? ST_IDLE : ST_U_ADD;
      end
      ST_U_ADD:  state_d = ST_U_RD;
      ST_Q_L: begin
        if (!l_lt_r) begin
          state_d = ST_DONE;
        end else if (lnode_q[0]) begin
          state_d = ST_Q_LACC;
        end else begin
          state_d = ST_Q_R;
        end
      end
      ST_Q_LACC: state_d = ST_Q_R;
      ST_Q_R:    state_d = rnode_q[0] ? ST_Q_RACC : ST_Q_L;
      ST_Q_RACC: state_d = ST_Q_L;
      ST_DONE: begin
        if (can_load) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Datapath control.
  always_comb begin
    we_odd      = 1'b0;
    we_even     = 1'b0;
    mem_re      = 1'b0;
    waddr       = lnode_q[AW:1];
    raddr       = lnode_q[AW-1:0];
    wdata       = alu_y;
    alu_a       = acc_q;
    alu_b       = odd_rd;
    alu_c       = even_rd;
    lnode_d     = lnode_q;
    rnode_d     = rnode_q;
    acc_d       = acc_q;
    par_d       = par_q;
    clr_d       = clr_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q & ~rsp.ready;
    unique case (state_q)
      ST_CLEAR: begin
        we_odd  = 1'b1;
        we_even = 1'b1;
        waddr   = clr_q;
        wdata   = '0;
        clr_d   = clr_q + AW'(1);
      end
      ST_IDLE: begin
        par_d   = rq.start_index[0];
        if (rq.req_type == REQ_QUERY) begin
          acc_d   = '0;
          lnode_d = NW'(rq.start_index) + NW'(SIZE);
          rnode_d = NW'(end_c) + NW'(SIZE);
        end else begin
          acc_d   = val_ext;
          lnode_d = leaf;
          waddr   = leaf[AW-1:0];
          wdata   = val_ext;
          if (req_fire && upd_ok) begin
            we_odd  = ~rq.start_index[0];
            we_even = rq.start_index[0];
          end
        end
      end
      ST_U_RD: begin
        // Read the sibling of the node just written.
        mem_re = 1'b1;
        raddr  = {lnode_q[AW-1:1], ~lnode_q[0]};
      end
      ST_U_ADD: begin
        alu_b   = par_q ? even_rd : odd_rd;
        alu_c   = '0;
        we_odd  = ~par_q;
        we_even = par_q;
        acc_d   = alu_y;
        lnode_d = lnode_q >> 1;
      end
      ST_Q_L: begin
        if (l_lt_r && lnode_q[0]) begin
          mem_re  = 1'b1;
          lnode_d = lnode_q + NW'(1);
        end
      end
      ST_Q_LACC: begin
        acc_d = alu_y;
      end
      ST_Q_R: begin
        if (rnode_q[0]) begin
          mem_re  = 1'b1;
          raddr   = r_dec[AW-1:0];
          rnode_d = r_dec;
        end else begin
          lnode_d = lnode_q >> 1;
          rnode_d = rnode_q >> 1;
        end
      end
      ST_Q_RACC: begin
        acc_d   = alu_y;
        lnode_d = lnode_q >> 1;
        rnode_d = rnode_q >> 1;
      end
      ST_DONE: begin
        // The accumulator holds odd-tree minus even-tree; flip it when the
        // range starts at an odd 0-based position.
        alu_a = par_q ? '0 : acc_q;
        alu_b = '0;
        alu_c = par_q ? acc_q : '0;
        if (can_load) begin
          out_data_d  = alu_y;
          out_valid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      count_q     <= CNT_RST;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg.valid && cfg.ready) begin
        count_q <= cfg.data.element_count;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lnode_q    <= lnode_d;
    rnode_q    <= rnode_d;
    acc_q      <= acc_d;
    par_q      <= par_d;
    out_data_q <= out_data_d;
  end

endmodule
